// ===== rtl/flood_duplicate_filter_forwarder_macros.svh =====
// assertion macros for the flooding engine
// no dependencies; included by the top level, which carries the assertions
`ifndef FLOOD_DUPLICATE_FILTER_FORWARDER_MACROS_SVH
`define FLOOD_DUPLICATE_FILTER_FORWARDER_MACROS_SVH

`ifndef SYNTHESIS
// checked property, masked while reset is asserted
`define FDDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also active during reset
`define FDDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDDF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/fddf_pkg.sv =====
// shared constants, codes and types of the flooding engine
// no dependencies
package fddf_pkg;

    localparam int SEEN_ENTRIES = 4;
    localparam int HEADER_BYTES = 7;
    // bytes one route hop adds to a frame
    localparam int HOP_BYTES    = 2;

    localparam int ADDR_W  = 16;
    localparam int ID_W    = 8;
    localparam int LEN_W   = 8;
    localparam int KEY_W   = ADDR_W + ID_W;
    localparam int TXLEN_W = 9;
    localparam int SUM_W   = 10;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    // event kinds
    localparam logic [FUNC_W-1:0] FUNC_RX     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TXDONE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUP       = 3'd3;
    localparam logic [STAT_W-1:0] ST_BUSY_FWD  = 3'd4;
    localparam logic [STAT_W-1:0] ST_HOPS      = 3'd5;
    localparam logic [STAT_W-1:0] ST_SEND_BUSY = 3'd6;
    localparam logic [STAT_W-1:0] ST_SEND_LONG = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVER_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOPS    = 3'd4;

    // register reset values
    localparam logic [ADDR_W-1:0] RST_NODE_ADDR   = 16'h0000;
    localparam logic [ADDR_W-1:0] RST_BCAST_ADDR  = 16'hFFFF;
    localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 8'd25;
    localparam logic [LEN_W-1:0]  RST_MAX_HOPS    = 8'd10;

    // control handed from the event logic to the seen row
    typedef struct packed {
        logic             record_en;
        logic [KEY_W-1:0] record_key;
        logic [KEY_W-1:0] probe_key;
    } t_row_ctl;

endpackage

// ===== rtl/fddf_cell.sv =====
// one entry of the seen row: a (source, id) key with its valid bit
// depends on fddf_pkg
module fddf_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fddf_pkg::t_row_ctl      i_ctl,
    input  logic [fddf_pkg::KEY_W-1:0] i_key,
    input  logic                    i_valid,
    input  logic                    i_hit,
    output logic [fddf_pkg::KEY_W-1:0] o_key,
    output logic                    o_valid,
    output logic                    o_hit
);
    import fddf_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.record_en) begin
            r_valid <= i_valid;
        end
    end

    // key takes the neighbor's entry when the row shifts
    always_ff @(posedge i_clk) begin
        if (i_ctl.record_en) begin
            r_key <= i_key;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_hit   = i_hit | (r_valid && (r_key == i_ctl.probe_key));

endmodule

// ===== rtl/fddf_row.sv =====
// row of seen cells: newest key enters at the head, oldest drops off the tail
// depends on fddf_pkg and fddf_cell
module fddf_row (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fddf_pkg::t_row_ctl i_ctl,
    output logic               o_hit
);
    import fddf_pkg::*;

    logic [KEY_W-1:0]      w_key [SEEN_ENTRIES+1];
    logic [SEEN_ENTRIES:0] w_valid;
    logic [SEEN_ENTRIES:0] w_hit;

    assign w_key[0]   = i_ctl.record_key;
    assign w_valid[0] = 1'b1;
    assign w_hit[0]   = 1'b0;

    for (genvar g = 0; g < SEEN_ENTRIES; g++) begin : g_cell
        fddf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_key   (w_key[g]),
            .i_valid (w_valid[g]),
            .i_hit   (w_hit[g]),
            .o_key   (w_key[g+1]),
            .o_valid (w_valid[g+1]),
            .o_hit   (w_hit[g+1])
        );
    end

    assign o_hit = w_hit[SEEN_ENTRIES];

endmodule

// ===== rtl/flood_duplicate_filter_forwarder.sv =====
// top level of the flooding engine with duplicate suppression
// depends on fddf_pkg, fddf_row, fddf_cell and the assertion macro header

// Flooding engine for one node. Each input beat is one event: a received
// frame header, a local send request or a transmit-done report; each gives
// exactly one result beat. Events are taken one per clock: the decision is
// made in the cycle of acceptance, node state (seen row, busy flag, next
// send id) updates at that edge, and the result appears from a one-deep
// output register on the next cycle. The input stays ready while that
// register is empty or being drained, so the rate is one beat per cycle
// unless the result side stalls. Recently seen (source, id) pairs live in a
// row of SEEN_ENTRIES cells that shifts the newest key in at the head; all
// cells are compared in the same cycle. Valid bits reset at once, so no
// clearing pass follows reset. Registers are written through the cfg port,
// always ready; the user writes only while no event is in flight (unchecked).
module flood_duplicate_filter_forwarder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fddf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fddf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // item_length[7:0] dst_address[23:8] src_address[39:24] header_id[47:40]
    // data_length[55:48] route_length[63:56] tx_failed[64], zeros above
    input  logic [fddf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [fddf_pkg::FUNC_W-1:0]     s_axis_tuser,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // deliver[0] forward[1] start_send[2] retry[3] frame_bytes[12:4]
    // new_route_length[20:13] assigned_id[28:21] busy_res[29], zeros above
    output logic [fddf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [fddf_pkg::STAT_W-1:0]     m_axis_tuser
);
    import fddf_pkg::*;
    `include "flood_duplicate_filter_forwarder_macros.svh"

    // configuration registers
    logic [ADDR_W-1:0] r_node_addr;
    logic [ADDR_W-1:0] r_bcast_addr;
    logic              r_deliver_en;
    logic [LEN_W-1:0]  r_max_payload;
    logic [LEN_W-1:0]  r_max_hops;

    // node state
    logic              r_tx_busy, n_tx_busy;
    logic [ID_W-1:0]   r_next_id, n_next_id;

    // result register
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_deliver, n_deliver;
    logic               r_forward, n_forward;
    logic               r_start, n_start;
    logic               r_retry, n_retry;
    logic [TXLEN_W-1:0] r_tx_len, n_tx_len;
    logic [LEN_W-1:0]   r_new_route, n_new_route;
    logic [ID_W-1:0]    r_aid, n_aid;

    // field decode
    logic [FUNC_W-1:0] w_func;
    logic [LEN_W-1:0]  w_len;
    logic [ADDR_W-1:0] w_dst;
    logic [ADDR_W-1:0] w_src;
    logic [ID_W-1:0]   w_hid;
    logic [LEN_W-1:0]  w_dlen;
    logic [LEN_W-1:0]  w_rlen;
    logic              w_failed;

    logic              w_in_beat;
    logic [SUM_W-1:0]  w_len_sum;
    logic              w_hit;
    logic              w_record;
    logic [KEY_W-1:0]  w_record_key;
    t_row_ctl          w_row_ctl;

    assign w_len    = s_axis_tdata[7:0];
    assign w_dst    = s_axis_tdata[23:8];
    assign w_src    = s_axis_tdata[39:24];
    assign w_hid    = s_axis_tdata[47:40];
    assign w_dlen   = s_axis_tdata[55:48];
    assign w_rlen   = s_axis_tdata[63:56];
    assign w_failed = s_axis_tdata[64];
    assign w_func   = s_axis_tuser;

    // output register frees up in the cycle its beat is taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // expected frame length: header + payload + two bytes per route hop
    assign w_len_sum = SUM_W'(HEADER_BYTES) + {2'b00, w_dlen} + {1'b0, w_rlen, 1'b0};

    always_comb begin
        n_status     = ST_OK;
        n_deliver    = 1'b0;
        n_forward    = 1'b0;
        n_start      = 1'b0;
        n_retry      = 1'b0;
        n_tx_len     = '0;
        n_new_route  = '0;
        n_aid        = '0;
        n_tx_busy    = r_tx_busy;
        n_next_id    = r_next_id;
        w_record     = 1'b0;
        w_record_key = {w_src, w_hid};
        case (w_func)
            FUNC_RX: begin
                if (w_len < LEN_W'(HEADER_BYTES)) begin
                    n_status = ST_SHORT;
                end else if (w_len_sum != {2'b00, w_len}) begin
                    n_status = ST_BAD_LEN;
                end else if (w_hit) begin
                    n_status = ST_DUP;
                end else begin
                    w_record = 1'b1;
                    n_deliver = r_deliver_en &&
                                ((w_dst == r_node_addr) || (w_dst == r_bcast_addr));
                    // frames for this node only are not passed on
                    if ((w_dst == r_bcast_addr) || (w_dst != r_node_addr)) begin
                        if (r_tx_busy) begin
                            n_status = ST_BUSY_FWD;
                        end else if (w_rlen >= r_max_hops) begin
                            n_status = ST_HOPS;
                        end else begin
                            n_forward   = 1'b1;
                            n_tx_len    = {1'b0, w_len} + TXLEN_W'(HOP_BYTES);
                            n_new_route = w_rlen + 8'd1;
                            n_tx_busy   = 1'b1;
                        end
                    end
                end
            end
            FUNC_SEND: begin
                if (r_tx_busy) begin
                    n_status = ST_SEND_BUSY;
                end else if (w_len > r_max_payload) begin
                    n_status = ST_SEND_LONG;
                end else begin
                    n_aid        = r_next_id;
                    n_next_id    = r_next_id + 8'd1;
                    w_record     = 1'b1;
                    w_record_key = {r_node_addr, r_next_id};
                    n_start      = 1'b1;
                    n_tx_len     = TXLEN_W'(HEADER_BYTES) + {1'b0, w_len} +
                                   TXLEN_W'(HOP_BYTES);
                    n_new_route  = 8'd1;
                    n_tx_busy    = 1'b1;
                end
            end
            FUNC_TXDONE: begin
                // report while idle is ignored
                if (r_tx_busy) begin
                    if (w_failed) begin
                        n_retry = 1'b1;
                    end else begin
                        n_tx_busy = 1'b0;
                    end
                end
            end
            default: begin
                // unknown event kind: no effect
            end
        endcase
    end

    assign w_row_ctl.record_en  = w_in_beat && w_record;
    assign w_row_ctl.record_key = w_record_key;
    assign w_row_ctl.probe_key  = {w_src, w_hid};

    fddf_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_row_ctl),
        .o_hit   (w_hit)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr   <= RST_NODE_ADDR;
            r_bcast_addr  <= RST_BCAST_ADDR;
            r_deliver_en  <= 1'b0;
            r_max_payload <= RST_MAX_PAYLOAD;
            r_max_hops    <= RST_MAX_HOPS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_NODE_ADDR:   r_node_addr   <= i_cfg_data;
                REG_BCAST_ADDR:  r_bcast_addr  <= i_cfg_data;
                REG_DELIVER_EN:  r_deliver_en  <= i_cfg_data[0];
                REG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[LEN_W-1:0];
                REG_MAX_HOPS:    r_max_hops    <= i_cfg_data[LEN_W-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // node state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_busy   <= 1'b0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_beat) begin
                r_tx_busy   <= n_tx_busy;
                r_next_id   <= n_next_id;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_status    <= n_status;
            r_deliver   <= n_deliver;
            r_forward   <= n_forward;
            r_start     <= n_start;
            r_retry     <= n_retry;
            r_tx_len    <= n_tx_len;
            r_new_route <= n_new_route;
            r_aid       <= n_aid;
        end
    end

    // busy_res is the busy flag left by the event, held in r_tx_busy
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, r_tx_busy, r_aid, r_new_route, r_tx_len,
                            r_retry, r_start, r_forward, r_deliver};

    // an event rejected for other than a busy forwarder or the hop limit yields no action
    `FDDF_ASSERT(a_reject_no_tx, i_clk, i_rst_n,
        (r_out_valid && (r_status != ST_OK) && (r_status != ST_BUSY_FWD) &&
         (r_status != ST_HOPS)) |-> !(r_forward || r_start || r_deliver),
        "rejected event produced an action")
    // the busy flag only clears on an accepted transmit-done beat
    `FDDF_ASSERT(a_busy_clear, i_clk, i_rst_n,
        $fell(r_tx_busy) |-> $past(w_in_beat && (w_func == FUNC_TXDONE)),
        "busy cleared without transmit done")
    // every accepted send advances the id by one
    `FDDF_ASSERT(a_id_step, i_clk, i_rst_n,
        (w_in_beat && n_start) |=> (r_next_id == ($past(r_next_id) + 8'd1)),
        "send id did not advance")
    // a transmission reported in a result leaves the node busy
    `FDDF_ASSERT(a_tx_busy, i_clk, i_rst_n,
        (r_out_valid && (r_forward || r_start)) |-> r_tx_busy,
        "transmission without busy")

endmodule
